FILE: src/wifi_descrambler_fcs_check_core_assert.svh
// assertion macros for the port-level checker
`ifndef WIFI_DESCRAMBLER_FCS_CHECK_CORE_ASSERT_SVH
`define WIFI_DESCRAMBLER_FCS_CHECK_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WDFC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wdfc assertion failed");

// next-cycle implication, disabled during reset
`define WDFC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wdfc assertion failed");

`endif

FILE: src/wdfc_pkg.sv
// shared types, constants and crc function for the descrambler / fcs check core
package wdfc_pkg;

   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
   localparam logic [31:0] CRC_RESIDUE = 32'h2144DF1C;

   localparam logic [15:0] SEED_BITS    = 16'd7;
   localparam logic [15:0] SERVICE_BITS = 16'd16;
   localparam logic [15:0] END_OFFSET   = 16'd15;
   localparam logic [13:0] FCS_BYTES    = 14'd4;
   localparam logic [12:0] SERVICE_BYTES = 13'd2;

   // one result beat
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       is_fcs;
      logic       last;
      logic       fcs_ok;
   } res_type;

   // reflected crc-32 over one byte, lsb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
      logic [31:0] crc;
      crc = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         crc = {1'b0, crc[31:1]} ^ (crc[0] ? CRC_POLY : 32'd0);
      end
      return crc;
   endfunction

endpackage

FILE: src/wdfc_frame_engine.sv
// per-bit descrambler, byte packer and crc-32 update with frame tracking
module wdfc_frame_engine
   import wdfc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        data_bit,
   input  logic        frame_start,
   input  logic [11:0] byte_count,
   output res_type     result
);

   logic [6:0]  scr_ff, scr_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  shift_ff, shift_in;
   logic [31:0] crc_ff, crc_in;
   logic [11:0] len_ff, len_in;
   logic        active_ff, active_in;

   logic        drop;
   logic        go;
   logic [15:0] p;
   logic [11:0] len_eff;
   logic [6:0]  scr_base;
   logic [7:0]  shift_base;
   logic [31:0] crc_base;
   logic [15:0] end_pos;
   logic        fb;
   logic        db;
   logic [12:0] idx;
   logic [31:0] crc_new;

   // frame start overrides the held frame context
   always_comb begin
      drop       = frame_start && ({20'd0, byte_count} > 32'(MAX_BYTES));
      go         = accept && !drop && (frame_start || active_ff);
      p          = frame_start ? 16'd0 : pos_ff;
      len_eff    = frame_start ? byte_count : len_ff;
      scr_base   = frame_start ? 7'd0 : scr_ff;
      shift_base = frame_start ? 8'd0 : shift_ff;
      crc_base   = frame_start ? CRC_INIT : crc_ff;
      end_pos    = {1'b0, len_eff, 3'b000} + END_OFFSET;
      fb         = scr_base[6] ^ scr_base[3];
      db         = fb ^ data_bit;
      idx        = 13'(p[15:3] - SERVICE_BYTES);
   end

   // next state and result
   always_comb begin
      scr_in    = scr_ff;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      crc_in    = crc_ff;
      len_in    = len_ff;
      active_in = active_ff;
      crc_new   = crc_byte(crc_base, {db, shift_base[7:1]});
      result    = '0;
      if (accept && drop) begin
         active_in = 1'b0;
      end else if (go) begin
         len_in    = len_eff;
         pos_in    = 16'(p + 16'd1);
         active_in = (p < end_pos);
         crc_in    = crc_base;
         shift_in  = shift_base;
         // seed bits load the scrambler, later bits run the lfsr
         if (p < SEED_BITS) begin
            scr_in = scr_base;
            scr_in[3'd6 - p[2:0]] = data_bit;
         end else begin
            scr_in = {scr_base[5:0], fb};
         end
         // pack descrambled bits after the service field
         if (p >= SERVICE_BITS) begin
            shift_in = {db, shift_base[7:1]};
            if (p[2:0] == 3'd7) begin
               crc_in           = crc_new;
               result.valid     = 1'b1;
               result.data_byte = shift_in;
               result.is_fcs    = ({1'b0, idx} + FCS_BYTES) >= {2'b00, len_eff};
               result.last      = (p == end_pos);
               result.fcs_ok    = (p == end_pos) && ((~crc_new) == CRC_RESIDUE);
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_ff    <= 7'd0;
         pos_ff    <= 16'd0;
         shift_ff  <= 8'd0;
         crc_ff    <= CRC_INIT;
         len_ff    <= 12'd0;
         active_ff <= 1'b0;
      end else begin
         scr_ff    <= scr_in;
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         crc_ff    <= crc_in;
         len_ff    <= len_in;
         active_ff <= active_in;
      end
   end

endmodule

FILE: src/wifi_descrambler_fcs_check_core.sv
// top level: bit engine feeding a registered result beat with one skid entry
//
//  channel | dir | ports                                         | beat
//  req     | in  | req_valid req_stall req_data_bit              | one scrambled bit
//          |     | req_frame_start req_byte_count                |
//  rsp     | out | rsp_valid rsp_stall rsp_data_byte rsp_is_fcs  | one payload byte
//          |     | rsp_last rsp_fcs_ok                           |
//
// one bit per cycle while req_stall is low: the scrambler, byte packer and crc byte
// update all run in the cycle a bit is accepted; a byte beat reaches rsp from the output register.
// reset is synchronous and leaves the block idle with no frame open.
// a stalled rsp beat holds; the next byte waits in the skid entry and req_stall
// rises only while that entry is occupied, so bits keep flowing meanwhile.
module wifi_descrambler_fcs_check_core
   import wdfc_pkg::*;
#(
   parameter int unsigned MAX_BYTES = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_data_bit,
   input  logic        req_frame_start,
   input  logic [11:0] req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_is_fcs,
   output logic        rsp_last,
   output logic        rsp_fcs_ok
);

   res_type new_res;
   res_type out_ff, out_in;
   res_type skid_ff, skid_in;
   logic    req_accept;
   logic    rsp_take;

   assign req_stall  = skid_ff.valid;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = out_ff.valid && !rsp_stall;

   wdfc_frame_engine #(
      .MAX_BYTES(MAX_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_bit    (req_data_bit),
      .frame_start (req_frame_start),
      .byte_count  (req_byte_count),
      .result      (new_res)
   );

   // output register and skid steering
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (rsp_take) begin
         out_in.valid = 1'b0;
      end
      if (skid_ff.valid && rsp_take) begin
         out_in        = skid_ff;
         skid_in.valid = 1'b0;
      end else if (new_res.valid) begin
         if (!out_ff.valid || rsp_take) begin
            out_in = new_res;
         end else begin
            skid_in = new_res;
         end
      end
   end

   // valid bits with reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         out_ff.valid  <= out_in.valid;
         skid_ff.valid <= skid_in.valid;
      end
      out_ff.data_byte  <= out_in.data_byte;
      out_ff.is_fcs     <= out_in.is_fcs;
      out_ff.last       <= out_in.last;
      out_ff.fcs_ok     <= out_in.fcs_ok;
      skid_ff.data_byte <= skid_in.data_byte;
      skid_ff.is_fcs    <= skid_in.is_fcs;
      skid_ff.last      <= skid_in.last;
      skid_ff.fcs_ok    <= skid_in.fcs_ok;
   end

   assign rsp_valid     = out_ff.valid;
   assign rsp_data_byte = out_ff.data_byte;
   assign rsp_is_fcs    = out_ff.is_fcs;
   assign rsp_last      = out_ff.last;
   assign rsp_fcs_ok    = out_ff.fcs_ok;

endmodule

FILE: src/wdfc_checker.sv
// port-level checker for the descrambler / fcs check core, with its bind
`include "wifi_descrambler_fcs_check_core_assert.svh"

module wdfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_is_fcs,
   input logic        rsp_last,
   input logic        rsp_fcs_ok
);

   // a stalled byte beat holds
   `WDFC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data_byte) && $stable(rsp_is_fcs) && $stable(rsp_last) && $stable(rsp_fcs_ok))
   // fcs match only reported on the closing byte, which is always an fcs byte
   `WDFC_ASSERT_IMP(a_ok_on_last, clock, reset, rsp_valid && (rsp_fcs_ok || rsp_last), rsp_last && rsp_is_fcs)
   // input only backs up behind a waiting byte
   `WDFC_ASSERT_IMP(a_stall_needs_out, clock, reset, req_stall, rsp_valid)
   // a taken byte drains the skid entry
   `WDFC_ASSERT_NXT(a_take_frees, clock, reset, rsp_valid && !rsp_stall, !req_stall)

endmodule

bind wifi_descrambler_fcs_check_core wdfc_checker u_wdfc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_data_byte (rsp_data_byte),
   .rsp_is_fcs    (rsp_is_fcs),
   .rsp_last      (rsp_last),
   .rsp_fcs_ok    (rsp_fcs_ok)
);

FILE: sim/tb_wifi_descrambler_fcs_check_core.sv
`timescale 1ns / 1ps
// testbench for the descrambler / fcs check core: scrambled frames against a predictor
module tb_wifi_descrambler_fcs_check_core;
   import wdfc_pkg::*;

   localparam int MAX_FRAME_BYTES = 4095;
   localparam int CYCLE_LIMIT     = 20000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int IDLE_PERCENT    = 37;
   localparam int REPORT_LIMIT    = 10;

   // one payload byte beat as seen on rsp
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_fcs;
      logic       last;
      logic       fcs_ok;
   } byte_beat_type;

   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_data_bit    = 1'b0;
   logic        req_frame_start = 1'b0;
   logic [11:0] req_byte_count  = 12'd0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_is_fcs;
   logic        rsp_last;
   logic        rsp_fcs_ok;

   // descrambler predictor state
   logic [6:0]  lfsr_state = 7'd0;
   int          bit_index  = 0;
   logic [7:0]  byte_accum = 8'd0;
   logic [31:0] crc_accum  = CRC_INIT;
   int          frame_len  = 0;
   logic        in_frame   = 1'b0;

   byte_beat_type expected_bytes[$];
   int          predicted_bytes = 0;
   int          frame_bits      = 0;
   int          error_count     = 0;
   int          cycle_count     = 0;
   logic        idle_on         = 1'b1;

   wifi_descrambler_fcs_check_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_bit    (req_data_bit),
      .req_frame_start (req_frame_start),
      .req_byte_count  (req_byte_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_is_fcs      (rsp_is_fcs),
      .rsp_last        (rsp_last),
      .rsp_fcs_ok      (rsp_fcs_ok)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // bit-serial reflected crc-32 over one byte
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] acc;
      logic        fbk;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fbk = acc[0] ^ data[i];
         acc = acc >> 1;
         if (fbk) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   // advance the predictor by one accepted bit, queue a byte beat when one completes
   task automatic descramble_bit(input logic b, input logic s, input logic [11:0] n);
      int            pos;
      int            end_pos;
      int            idx;
      logic          fb;
      logic          db;
      byte_beat_type beat;
      if (s) begin
         if (int'(n) > MAX_FRAME_BYTES) begin
            in_frame = 1'b0;
            return;
         end
         in_frame   = 1'b1;
         frame_len  = int'(n);
         bit_index  = 0;
         lfsr_state = 7'd0;
         byte_accum = 8'd0;
         crc_accum  = CRC_INIT;
      end
      if (!in_frame) return;
      pos     = bit_index;
      end_pos = frame_len * 8 + 15;
      db      = 1'b0;
      // seed bits load the lfsr directly, top bit first
      if (pos < 7) begin
         lfsr_state = lfsr_state | (7'(b) << (6 - pos));
      end else begin
         fb         = lfsr_state[6] ^ lfsr_state[3];
         db         = fb ^ b;
         lfsr_state = {lfsr_state[5:0], fb};
      end
      bit_index = (pos + 1) & 16'hFFFF;
      if (pos >= end_pos) in_frame = 1'b0;
      // service field is consumed without output
      if (pos < 16) return;
      byte_accum = {db, byte_accum[7:1]};
      if (pos % 8 != 7) return;
      idx            = pos / 8 - 2;
      crc_accum      = crc32_step(crc_accum, byte_accum);
      beat.data_byte = byte_accum;
      beat.is_fcs    = (idx + 4 >= frame_len);
      beat.last      = (pos == end_pos);
      beat.fcs_ok    = beat.last && ((~crc_accum) == CRC_RESIDUE);
      expected_bytes.push_back(beat);
      predicted_bytes++;
   endtask

   // present one bit beat, wait for acceptance, then predict
   task automatic send_bit(input logic b, input logic s, input logic [11:0] n);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid       <= 1'b0;
         req_data_bit    <= 1'($urandom_range(1));
         req_frame_start <= 1'($urandom_range(1));
         req_byte_count  <= 12'($urandom_range(4095));
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_bit    <= b;
      req_frame_start <= s;
      req_byte_count  <= n;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      descramble_bit(b, s, n);
   endtask

   // build a frame with random payload and fcs, scramble it and send it bit by bit;
   // corrupt flips one bit of the frame bytes, cut_bits >= 0 stops the frame early
   task automatic send_frame(input int n_bytes, input logic corrupt, input int cut_bits);
      logic [7:0]  body[$];
      logic [7:0]  cur;
      logic [31:0] crc;
      logic [6:0]  tx_state;
      logic        fb;
      logic        db;
      logic        raw;
      int          total;
      int          flip;
      crc = CRC_INIT;
      for (int i = 0; i < n_bytes; i++) begin
         if (n_bytes >= 4 && i >= n_bytes - 4) begin
            body.push_back(~crc[8 * (i - n_bytes + 4) +: 8]);
         end else begin
            body.push_back(8'($urandom));
            crc = crc32_step(crc, body[i]);
         end
      end
      if (corrupt && n_bytes > 0) begin
         flip = $urandom_range(8 * n_bytes - 1);
         body[flip / 8] = body[flip / 8] ^ (8'd1 << (flip % 8));
      end
      total = 8 * n_bytes + 16;
      if (cut_bits >= 0 && cut_bits < total) total = cut_bits;
      tx_state = 7'd0;
      for (int p = 0; p < total; p++) begin
         if (p < 7) begin
            raw             = 1'($urandom_range(1));
            tx_state[6 - p] = raw;
         end else begin
            if (p < 16) begin
               db = 1'($urandom_range(1));
            end else begin
               cur = body[(p - 16) / 8];
               db  = cur[(p - 16) % 8];
            end
            fb       = tx_state[6] ^ tx_state[3];
            raw      = fb ^ db;
            tx_state = {tx_state[5:0], fb};
         end
         send_bit(raw, p == 0, (p == 0) ? 12'(n_bytes) : 12'($urandom));
         frame_bits++;
      end
   endtask

   // one compared field of a byte beat
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %02h, got %02h", name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      byte_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected byte beat: data %02h is_fcs %0b last %0b fcs_ok %0b",
                        rsp_data_byte, rsp_is_fcs, rsp_last, rsp_fcs_ok);
         end else begin
            want = expected_bytes.pop_front();
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("is_fcs", 8'(want.is_fcs), 8'(rsp_is_fcs));
            check_field("last", 8'(want.last), 8'(rsp_last));
            check_field("fcs_ok", 8'(want.fcs_ok), 8'(rsp_fcs_ok));
         end
      end
   end

   // receiver stalls and watchdog
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL wifi_descrambler_fcs_check_core");
         $finish;
      end
   end

   // bits with no frame open are ignored
   task automatic test_idle_bits;
      repeat (6) send_bit(1'($urandom_range(1)), 1'b0, 12'($urandom));
   endtask

   // well-formed frames, then bits past the frame end
   task automatic test_good_frames;
      send_frame(4, 1'b0, -1);
      send_frame(5, 1'b0, -1);
      repeat (4) send_bit(1'($urandom_range(1)), 1'b0, 12'($urandom));
   endtask

   // a flipped frame bit must clear fcs_ok
   task automatic test_bad_fcs;
      send_frame(4, 1'b1, -1);
   endtask

   // lengths 0 to 3: service only, or every byte flagged as fcs;
   // run as one long stretch with no idling on either side
   task automatic test_short_frames;
      idle_on = 1'b0;
      for (int n = 0; n < 4; n++) send_frame(n, 1'b0, -1);
      idle_on = 1'b1;
   endtask

   // restart mid-payload, then mid-seed
   task automatic test_restart;
      send_frame(6, 1'b0, 30);
      send_frame(5, 1'b0, 3);
   endtask

   // longest length the field allows, cut after the first payload bytes
   task automatic test_max_length;
      send_frame(MAX_FRAME_BYTES, 1'b0, 40);
   endtask

   // mostly well-formed frames with random content, some broken ones and noise
   task automatic test_random;
      int bits0;
      int bytes0;
      int n;
      int pick;
      bits0  = frame_bits;
      bytes0 = predicted_bytes;
      while (frame_bits - bits0 < 64 || predicted_bytes - bytes0 < 6) begin
         pick = $urandom_range(99);
         n    = $urandom_range(4, 8);
         if (pick < 70)
            send_frame(n, 1'b0, -1);
         else if (pick < 80)
            send_frame(n, 1'b1, -1);
         else if (pick < 88)
            send_frame(n, 1'($urandom_range(1)), $urandom_range(8 * n + 15));
         else if (pick < 94)
            send_frame($urandom_range(3), 1'b0, -1);
         else
            repeat ($urandom_range(1, 5))
               send_bit(1'($urandom_range(1)), 1'b0, 12'($urandom));
      end
   endtask

   // reset, tests in turn, drain and verdict
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bits;
      test_good_frames;
      test_bad_fcs;
      test_short_frames;
      test_restart;
      test_random;
      test_max_length;
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS wifi_descrambler_fcs_check_core");
      else
         $display("FAIL wifi_descrambler_fcs_check_core");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/wdfc_pkg.sv
src/wdfc_frame_engine.sv
src/wifi_descrambler_fcs_check_core.sv
src/wdfc_checker.sv
sim/tb_wifi_descrambler_fcs_check_core.sv
